// ----- rtl/core/heat1d_pkg.sv -----
// package for the periodic one-dimensional heat diffusion step block
// holds widths, request codes, register offsets, sequencer states and read tags
// no dependencies
package heat1d_pkg;

    // cell store geometry
    localparam int MAX_CELLS = 1024;
    localparam int CELL_AW   = $clog2(MAX_CELLS);
    localparam int CNT_W     = CELL_AW + 1;

    // datapath widths
    localparam int TEMP_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int SUM_W   = TEMP_W + CELL_AW;
    localparam int LAP_W   = TEMP_W + 2;
    localparam int MUL_A_W = SUM_W;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RES_W   = 64;
    localparam int STEP_W  = TEMP_W + 5;

    // configuration port
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int ACTIVE_W = 11;

    localparam logic [1:0] REG_ACTIVE_CELLS   = 2'd0;
    localparam logic [1:0] REG_DIFFUSION_GAIN = 2'd1;
    localparam logic [1:0] REG_CELL_SPACING   = 2'd2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_CELLS_RST = ACTIVE_W'(MAX_CELLS);
    localparam logic [PDATA_W-1:0]  CELL_SPACING_RST = 32'h0001_0000;

    // rounding constant for a q16 right shift
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // request codes
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_HEAT  = 2'd3
    } req_type_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_STEP_LEFT,
        ST_STEP_FIRST,
        ST_STEP,
        ST_SUM,
        ST_HEAT_LO,
        ST_HEAT_HI,
        ST_HEAT_FIN,
        ST_RESP
    } state_t;

    // meaning of the registered memory read data in the cycle after issue
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_LEFT,
        TAG_FIRST,
        TAG_STREAM,
        TAG_WRAP,
        TAG_SUM
    } rd_tag_t;

endpackage

// ----- rtl/core/heat_diffusion_1d_periodic_step.sv -----
// top level of the periodic one-dimensional heat diffusion step block
// holds the cell memory, the request sequencer and the shared multiplier
// depends on heat1d_pkg
//
// Holds up to 1024 signed Q16.16 cell temperatures as a ring of active_cells cells and
// serves one request at a time: write cell, read cell, explicit time step of every active
// cell, and total heat (cell sum times spacing, rounded to Q16.16). Every request gives
// exactly one result beat. After reset the block sweeps zeros through the cell memory,
// one cell per cycle, and takes no request meanwhile; configuration writes are taken at
// any time but belong to idle periods. A time step and a total heat request both walk the
// ring of active cells through the single read port of the cell memory at one cell per
// cycle, and the step streams each cell through one shared 42 x 16 multiplier with a
// lap, multiply, and round and write-back pipeline.
// Configuration registers sit on an APB-style port at byte offsets 0, 4 and 8.
module heat_diffusion_1d_periodic_step (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [heat1d_pkg::CELL_AW-1:0]      s_cell_index,
    input  logic signed [heat1d_pkg::TEMP_W-1:0] s_temp_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [heat1d_pkg::RES_W-1:0] m_result_value,
    output logic                                m_bad_index,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [heat1d_pkg::PADDR_W-1:0]      paddr,
    input  logic [heat1d_pkg::PDATA_W-1:0]      pwdata,
    output logic [heat1d_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready
);
    import heat1d_pkg::*;

    // configuration registers
    logic [ACTIVE_W-1:0] active_cells_reg;
    logic [GAIN_W-1:0]   diffusion_gain_reg;
    logic [PDATA_W-1:0]  cell_spacing_reg;
    logic                cfg_write;

    // sequencer
    state_t state_reg, state_next;
    rd_tag_t tag_reg, issue_tag;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic [CNT_W-1:0] comp_cnt_reg;
    logic             cnt_clr, cnt_inc;
    logic             s_accept;

    // cell memory
    logic [TEMP_W-1:0]  cell_mem [MAX_CELLS];
    logic [TEMP_W-1:0]  rd_data_reg;
    logic               rd_en, wr_en;
    logic [CELL_AW-1:0] rd_addr, wr_addr;
    logic [TEMP_W-1:0]  wr_data;

    // ring size
    logic [CNT_W-1:0]   n_cells;
    logic [CNT_W-1:0]   n_minus;
    logic [CELL_AW-1:0] last_idx;
    logic               idx_bad;

    // step pipeline
    logic [TEMP_W-1:0]  held_left_old_reg;
    logic [TEMP_W-1:0]  held_first_old_reg;
    logic [TEMP_W-1:0]  cur_old_reg;
    logic [TEMP_W-1:0]  right_val;
    logic [LAP_W-1:0]   lap_calc;
    logic [LAP_W-1:0]   lap_reg;
    logic [TEMP_W-1:0]  t1_reg, t2_reg;
    logic [CELL_AW-1:0] wa1_reg, wa2_reg;
    logic               s1_vld_reg, s2_vld_reg;
    logic               neg2_reg;
    logic [LAP_W-1:0]   step_mag;
    logic [STEP_W-1:0]  step_q, step_delta, step_new;
    logic [TEMP_W-1:0]  step_sat;
    logic               step_done;

    // shared multiplier and rounding
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  rnd_sum;
    logic [MUL_A_W-1:0] rnd_q;

    // total heat
    logic [SUM_W-1:0]   heat_acc_reg;
    logic [SUM_W-1:0]   heat_mag;
    logic [MUL_A_W-1:0] lo_part_reg;
    logic [PROD_W:0]    heat_q;
    logic [RES_W-1:0]   heat_res;

    // result staging and output register
    logic [RES_W-1:0] res_reg;
    logic             bad_reg;
    logic             out_free;
    logic             m_valid_reg;
    logic [RES_W-1:0] m_result_reg;
    logic             m_bad_reg;

    // configuration writes and reads
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cells_reg   <= ACTIVE_CELLS_RST;
            diffusion_gain_reg <= '0;
            cell_spacing_reg   <= CELL_SPACING_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_ACTIVE_CELLS:   active_cells_reg   <= pwdata[ACTIVE_W-1:0];
                REG_DIFFUSION_GAIN: diffusion_gain_reg <= pwdata[GAIN_W-1:0];
                REG_CELL_SPACING:   cell_spacing_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE_CELLS:   prdata = {{(PDATA_W-ACTIVE_W){1'b0}}, active_cells_reg};
            REG_DIFFUSION_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, diffusion_gain_reg};
            REG_CELL_SPACING:   prdata = cell_spacing_reg;
            default:            prdata = '0;
        endcase
    end

    // effective ring size, saturated to the store depth
    assign n_cells  = (active_cells_reg > ACTIVE_CELLS_RST) ? CNT_W'(MAX_CELLS)
                                                            : CNT_W'(active_cells_reg);
    assign n_minus  = n_cells - CNT_W'(1);
    assign last_idx = n_minus[CELL_AW-1:0];
    assign idx_bad  = ({1'b0, s_cell_index} >= n_cells);
    assign s_accept = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // step completes when the last ring cell is written back
    assign step_done = s2_vld_reg && (wa2_reg == last_idx);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (issue_cnt_reg[CELL_AW-1:0] == CELL_AW'(MAX_CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_req_type)
                        REQ_WRITE: state_next = ST_RESP;
                        REQ_READ:  state_next = ST_RD_WAIT;
                        REQ_STEP:  state_next = (n_cells == '0) ? ST_RESP : ST_STEP_LEFT;
                        REQ_HEAT:  state_next = ST_SUM;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_RD_WAIT:    state_next = ST_RESP;
            ST_STEP_LEFT:  state_next = ST_STEP_FIRST;
            ST_STEP_FIRST: state_next = ST_STEP;
            ST_STEP: begin
                if (step_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_SUM: begin
                if (issue_cnt_reg == n_cells && tag_reg == TAG_NONE) begin
                    state_next = ST_HEAT_LO;
                end
            end
            ST_HEAT_LO:  state_next = ST_HEAT_HI;
            ST_HEAT_HI:  state_next = ST_HEAT_FIN;
            ST_HEAT_FIN: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: memory ports, counter control, multiplier operands
    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        issue_tag = TAG_NONE;
        cnt_clr   = 1'b0;
        cnt_inc   = 1'b0;
        mul_a     = {{(MUL_A_W-LAP_W){1'b0}}, step_mag};
        mul_b     = diffusion_gain_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = issue_cnt_reg[CELL_AW-1:0];
                cnt_inc = 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                cnt_clr = s_accept;
                if (s_accept && s_req_type == REQ_WRITE && !idx_bad) begin
                    wr_en   = 1'b1;
                    wr_addr = s_cell_index;
                    wr_data = s_temp_value;
                end
                if (s_accept && s_req_type == REQ_READ) begin
                    rd_en   = 1'b1;
                    rd_addr = s_cell_index;
                end
            end
            ST_STEP_LEFT: begin
                rd_en     = 1'b1;
                rd_addr   = last_idx;
                issue_tag = TAG_LEFT;
            end
            ST_STEP_FIRST: begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                issue_tag = TAG_FIRST;
                cnt_inc   = 1'b1;
            end
            ST_STEP: begin
                if (issue_cnt_reg < n_cells) begin
                    rd_en     = 1'b1;
                    rd_addr   = issue_cnt_reg[CELL_AW-1:0];
                    issue_tag = TAG_STREAM;
                    cnt_inc   = 1'b1;
                end else if (issue_cnt_reg == n_cells) begin
                    issue_tag = TAG_WRAP;
                    cnt_inc   = 1'b1;
                end
                wr_en   = s2_vld_reg;
                wr_addr = wa2_reg;
                wr_data = step_sat;
            end
            ST_SUM: begin
                if (issue_cnt_reg < n_cells) begin
                    rd_en     = 1'b1;
                    rd_addr   = issue_cnt_reg[CELL_AW-1:0];
                    issue_tag = TAG_SUM;
                    cnt_inc   = 1'b1;
                end
            end
            ST_HEAT_LO: begin
                mul_a = heat_mag;
                mul_b = cell_spacing_reg[15:0];
            end
            ST_HEAT_HI: begin
                mul_a = heat_mag;
                mul_b = cell_spacing_reg[31:16];
            end
            default: ;
        endcase
    end

    // state, tag and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            tag_reg       <= TAG_NONE;
            issue_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            tag_reg   <= issue_tag;
            if (cnt_clr) begin
                issue_cnt_reg <= '0;
            end else if (cnt_inc) begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
        end
    end

    // cell memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    // stage one: laplacian from old left, old centre and right neighbour
    assign right_val = (tag_reg == TAG_WRAP) ? held_first_old_reg : rd_data_reg;
    assign lap_calc  = {{2{right_val[TEMP_W-1]}}, right_val}
                     + {{2{held_left_old_reg[TEMP_W-1]}}, held_left_old_reg}
                     - {cur_old_reg[TEMP_W-1], cur_old_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_left_old_reg  <= '0;
            held_first_old_reg <= '0;
            heat_acc_reg       <= '0;
            s1_vld_reg         <= 1'b0;
            s2_vld_reg         <= 1'b0;
            comp_cnt_reg       <= '0;
        end else begin
            s1_vld_reg <= (tag_reg == TAG_STREAM) || (tag_reg == TAG_WRAP);
            if (cnt_clr) begin
                comp_cnt_reg <= '0;
            end
            if (cnt_clr && s_req_type == REQ_HEAT) begin
                heat_acc_reg <= '0;
            end
            case (tag_reg)
                TAG_LEFT: held_left_old_reg <= rd_data_reg;
                TAG_FIRST: begin
                    cur_old_reg        <= rd_data_reg;
                    held_first_old_reg <= rd_data_reg;
                end
                TAG_STREAM, TAG_WRAP: begin
                    lap_reg           <= lap_calc;
                    t1_reg            <= cur_old_reg;
                    wa1_reg           <= comp_cnt_reg[CELL_AW-1:0];
                    comp_cnt_reg      <= comp_cnt_reg + CNT_W'(1);
                    held_left_old_reg <= cur_old_reg;
                    cur_old_reg       <= right_val;
                end
                TAG_SUM: begin
                    heat_acc_reg <= heat_acc_reg
                                  + {{(SUM_W-TEMP_W){rd_data_reg[TEMP_W-1]}}, rd_data_reg};
                end
                default: ;
            endcase
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // stage two: shared multiplier, magnitude times gain or sum times spacing half
    assign step_mag = lap_reg[LAP_W-1] ? (~lap_reg + LAP_W'(1)) : lap_reg;
    assign heat_mag = heat_acc_reg[SUM_W-1] ? (~heat_acc_reg + SUM_W'(1)) : heat_acc_reg;
    assign mul_prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    always_ff @(posedge aclk) begin
        prod_reg <= mul_prod;
        neg2_reg <= lap_reg[LAP_W-1];
        t2_reg   <= t1_reg;
        wa2_reg  <= wa1_reg;
    end

    // stage three: round to nearest with ties away from zero, add, saturate
    assign rnd_sum    = prod_reg + ROUND_HALF;
    assign rnd_q      = rnd_sum[PROD_W-1:16];
    assign step_q     = {2'b00, rnd_q[LAP_W:0]};
    assign step_delta = neg2_reg ? (~step_q + STEP_W'(1)) : step_q;
    assign step_new   = {{(STEP_W-TEMP_W){t2_reg[TEMP_W-1]}}, t2_reg} + step_delta;

    always_comb begin
        if (step_new[STEP_W-1:TEMP_W-1] == '0 || step_new[STEP_W-1:TEMP_W-1] == '1) begin
            step_sat = step_new[TEMP_W-1:0];
        end else if (step_new[STEP_W-1]) begin
            step_sat = {1'b1, {(TEMP_W-1){1'b0}}};
        end else begin
            step_sat = {1'b0, {(TEMP_W-1){1'b1}}};
        end
    end

    // total heat: integer part product plus rounded fraction part product
    assign heat_q   = {1'b0, prod_reg} + {{(PROD_W+1-MUL_A_W){1'b0}}, lo_part_reg};
    assign heat_res = heat_acc_reg[SUM_W-1]
                    ? (~{{(RES_W-PROD_W-1){1'b0}}, heat_q} + RES_W'(1))
                    : {{(RES_W-PROD_W-1){1'b0}}, heat_q};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_HEAT_HI) begin
            lo_part_reg <= rnd_q;
        end
    end

    // staged result of the current request
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_reg <= '0;
                    bad_reg <= (s_req_type == REQ_WRITE || s_req_type == REQ_READ) && idx_bad;
                end
            end
            ST_RD_WAIT: begin
                res_reg <= bad_reg ? '0
                                   : {{(RES_W-TEMP_W){rd_data_reg[TEMP_W-1]}}, rd_data_reg};
            end
            ST_HEAT_FIN: res_reg <= heat_res;
            default: ;
        endcase
    end

    // output register, loaded when the result beat slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_RESP && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RESP && out_free) begin
            m_result_reg <= res_reg;
            m_bad_reg    <= bad_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_bad_index    = m_bad_reg;

    // step write-back walks the ring in order
    a_step_wb_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg && $past(s2_vld_reg) |-> wa2_reg == $past(wa2_reg) + CELL_AW'(1))
        else $error("step write-back out of order");

    // every accepted request leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // read data tags only pending while walking the ring
    a_tag_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_reg != TAG_NONE |-> (state_reg == ST_STEP_FIRST || state_reg == ST_STEP
                                 || state_reg == ST_SUM || state_reg == ST_HEAT_LO))
        else $error("read tag pending outside a ring walk");

    // a result beat only appears out of the response state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RESP)
        else $error("result beat raised outside the response state");

endmodule

// ----- sim/heat_diffusion_1d_periodic_step_tb.sv -----
// testbench for the periodic one-dimensional heat diffusion step block
// drives request beats, apb register writes and result back-pressure, checks every result beat
// depends on heat1d_pkg and heat_diffusion_1d_periodic_step
module heat_diffusion_1d_periodic_step_tb;
    import heat1d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_500_000;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    bad;
    } row_answer_t;

    // row predictor and result queue
    class heat_row_scoreboard;
        logic [ACTIVE_W-1:0]      active_cells;
        logic [GAIN_W-1:0]        gain;
        logic [31:0]              spacing;
        logic signed [TEMP_W-1:0] cells [MAX_CELLS];
        row_answer_t              pending_answers [$];
        int unsigned              errors;

        function new();
            active_cells = ACTIVE_CELLS_RST;
            gain         = '0;
            spacing      = CELL_SPACING_RST;
            errors       = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function void report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [1:0] reg_id, logic [31:0] value);
            case (reg_id)
                REG_ACTIVE_CELLS:   active_cells = value[ACTIVE_W-1:0];
                REG_DIFFUSION_GAIN: gain = value[GAIN_W-1:0];
                REG_CELL_SPACING:   spacing = value;
                default: ;
            endcase
        endfunction

        // counts above the store size clamp to the store size
        function int unsigned ring_size();
            return (active_cells > MAX_CELLS) ? MAX_CELLS : active_cells;
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction

        // explicit update of every ring cell from the old neighbour values
        function void advance_step(int unsigned n);
            logic signed [TEMP_W-1:0] old_cells [MAX_CELLS];
            longint                   lap;
            longint                   delta;
            longint                   upd;
            longint unsigned          mag;
            longint unsigned          q;
            if (n == 0) return;
            old_cells = cells;
            for (int unsigned i = 0; i < n; i++) begin
                lap = longint'(old_cells[(i + 1) % n]) - 2 * longint'(old_cells[i])
                      + longint'(old_cells[(i + n - 1) % n]);
                mag = (lap < 0) ? -lap : lap;
                // round to nearest, ties away from zero
                q = (mag * gain + 64'd32768) >> 16;
                delta = (lap < 0) ? -longint'(q) : longint'(q);
                upd = longint'(old_cells[i]) + delta;
                if (upd > 64'sd2147483647)
                    cells[i] = 32'sh7FFF_FFFF;
                else if (upd < -64'sd2147483648)
                    cells[i] = 32'sh8000_0000;
                else
                    cells[i] = upd[TEMP_W-1:0];
            end
        endfunction

        // ring sum times spacing, both q16.16
        function longint heat_total(int unsigned n);
            longint          sum;
            longint unsigned mag;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned q;
            sum = 0;
            for (int unsigned i = 0; i < n; i++) sum += longint'(cells[i]);
            mag = (sum < 0) ? -sum : sum;
            hi  = spacing[31:16];
            lo  = spacing[15:0];
            q   = mag * hi + ((mag * lo + 64'd32768) >> 16);
            return (sum < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_request(req_type_t kind, logic [CELL_AW-1:0] idx,
                                   logic signed [TEMP_W-1:0] temp);
            row_answer_t answer;
            int unsigned n;
            n = ring_size();
            answer.value = '0;
            answer.bad   = 1'b0;
            case (kind)
                REQ_WRITE: begin
                    if (idx >= n) answer.bad = 1'b1;
                    else cells[idx] = temp;
                end
                REQ_READ: begin
                    if (idx >= n) answer.bad = 1'b1;
                    else answer.value = cells[idx];
                end
                REQ_STEP: advance_step(n);
                default:  answer.value = heat_total(n);
            endcase
            pending_answers.push_back(answer);
        endfunction

        function void check_result(logic signed [RES_W-1:0] value, logic bad);
            row_answer_t want;
            if (pending_answers.size() == 0) begin
                report($sformatf("result beat with nothing outstanding (value %0d bad %0b)",
                                 value, bad));
                return;
            end
            want = pending_answers.pop_front();
            if (value !== want.value)
                report($sformatf("result_value %0d, expected %0d", value, want.value));
            if (bad !== want.bad)
                report($sformatf("bad_index %0b, expected %0b", bad, want.bad));
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_req_type;
    logic [CELL_AW-1:0]          s_cell_index;
    logic signed [TEMP_W-1:0]    s_temp_value;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [RES_W-1:0]     m_result_value;
    logic                        m_bad_index;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;

    heat_row_scoreboard sb = new();
    bit                 calm = 1'b0;
    int unsigned        cycle_count = 0;

    heat_diffusion_1d_periodic_step i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_cell_index   (s_cell_index),
        .s_temp_value   (s_temp_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_bad_index    (m_bad_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // idle cycles before a beat, none in calm phases
    function automatic int unsigned pick_wait();
        if (calm || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 12);
    endfunction

    // apb write, then read back through the same port
    task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        case (reg_id)
            REG_ACTIVE_CELLS:   mask = 32'h0000_07FF;
            REG_DIFFUSION_GAIN: mask = 32'h0000_FFFF;
            default:            mask = 32'hFFFF_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(reg_id, value & mask);
        if (readback !== (value & mask))
            sb.report($sformatf("register %0d reads %h, expected %h",
                                reg_id, readback, value & mask));
    endtask

    // one request beat; valid stays high afterwards until the next call or a drain
    task automatic send_req(input req_type_t kind, input logic [CELL_AW-1:0] idx,
                            input logic signed [TEMP_W-1:0] temp);
        int unsigned gap;
        gap = pick_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_cell_index <= idx;
        s_temp_value <= temp;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, idx, temp);
        @(negedge aclk);
    endtask

    // hold off until every outstanding result beat is back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic send_random();
        int unsigned              n;
        int unsigned              pick;
        req_type_t                kind;
        logic [CELL_AW-1:0]       idx;
        logic signed [TEMP_W-1:0] temp;
        n    = sb.ring_size();
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = REQ_WRITE;
        else if (pick < 65) kind = REQ_READ;
        else if (pick < 85) kind = REQ_STEP;
        else                kind = REQ_HEAT;
        // mostly in-ring indexes, some anywhere
        if (n != 0 && $urandom_range(0, 7) != 0) idx = $urandom_range(0, n - 1);
        else idx = $urandom_range(0, MAX_CELLS - 1);
        case ($urandom_range(0, 5))
            0:       temp = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            1:       temp = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       temp = 32'sh7F00_0000 + $signed($urandom_range(0, 32'h00FF_FFFF));
            default: temp = $urandom;
        endcase
        send_req(kind, idx, temp);
    endtask

    task automatic run_phase(input logic [31:0] cells_cfg, input logic [31:0] gain_cfg,
                             input logic [31:0] spacing_cfg, input int unsigned items,
                             input bit quiet);
        write_reg(REG_ACTIVE_CELLS, cells_cfg);
        write_reg(REG_DIFFUSION_GAIN, gain_cfg);
        write_reg(REG_CELL_SPACING, spacing_cfg);
        calm = quiet;
        repeat (items) send_random();
        drain();
    endtask

    // result side with random back-pressure
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pick_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result(m_result_value, m_bad_index);
            @(negedge aclk);
        end
    end

    // reset, directed requests, random phases
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_WRITE;
        s_cell_index = '0;
        s_temp_value = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // eight-cell ring, near-unity gain, widest spacing
        write_reg(REG_ACTIVE_CELLS, 32'd8);
        write_reg(REG_DIFFUSION_GAIN, 32'h0000_FFFF);
        write_reg(REG_CELL_SPACING, 32'hFFFF_FFFF);
        send_req(REQ_READ, 10'd0, '0);
        send_req(REQ_WRITE, 10'd0, 32'sh7FFF_FFFF);
        send_req(REQ_WRITE, 10'd7, 32'sh8000_0000);
        send_req(REQ_WRITE, 10'd3, 32'sh0001_0000);
        send_req(REQ_WRITE, 10'd1, -32'sd1);
        // indexes at and past the ring end are flagged
        send_req(REQ_WRITE, 10'd8, 32'sh1234_5678);
        send_req(REQ_WRITE, 10'd1023, 32'sh1234_5678);
        send_req(REQ_READ, 10'd8, '0);
        send_req(REQ_READ, 10'd1023, '0);
        send_req(REQ_READ, 10'd0, '0);
        send_req(REQ_READ, 10'd7, '0);
        send_req(REQ_HEAT, 10'd0, '0);
        // extremes next to each other saturate on the step
        send_req(REQ_STEP, 10'd0, '0);
        send_req(REQ_READ, 10'd0, '0);
        send_req(REQ_READ, 10'd1, '0);
        send_req(REQ_READ, 10'd6, '0);
        send_req(REQ_READ, 10'd7, '0);
        send_req(REQ_HEAT, 10'd0, '0);
        send_req(REQ_STEP, 10'd0, 32'shFFFF_FFFF);
        send_req(REQ_HEAT, 10'd1023, 32'shFFFF_FFFF);
        drain();

        // three-cell ring, half gain gives rounding ties
        run_phase(32'd3, 32'h0000_8000, 32'h0000_0001, 60, 1'b0);
        // full store, no diffusion
        run_phase(32'd1024, 32'h0000_0000, 32'hFFFF_FFFF, 30, 1'b1);
        // empty ring flags every index, zero spacing
        run_phase(32'd0, 32'h0000_FFFF, 32'h0000_0000, 15, 1'b0);
        // a single cell is its own neighbour
        run_phase(32'd1, 32'h0000_1234, $urandom, 20, 1'b0);
        run_phase(32'd2, $urandom_range(0, 65535), $urandom, 20, 1'b0);
        // count above the store clamps to the store
        run_phase(32'd2047, $urandom_range(0, 65535), $urandom, 25, 1'b0);
        for (int p = 0; p < 6; p++)
            run_phase($urandom_range(3, (p == 5) ? 200 : 48), $urandom_range(0, 65535),
                      $urandom, 68, p == 2);

        calm = 1'b0;
        repeat (40) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
